### rtl/core/spc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_pkg: shared types and constants for the two-channel speed regulator
// Fixed-point widths, register indexes, clamp codes and stage structs.
// ----------------------------------------------------------------------------
package spc_pkg;

	localparam int GAIN_W     = 16;                  // unsigned Q8.8
	localparam int SPEED_W    = 16;                  // signed Q4.12
	localparam int ERR_W      = SPEED_W + 1;         // signed Q5.12
	localparam int DIFF_W     = ERR_W + 1;           // signed Q6.12
	localparam int INTEG_BITS = 24;                  // integral width, 17..40
	localparam int INTEG_W    = INTEG_BITS;
	localparam int FRAC_W     = 20;                  // Q.8 gain times Q.12 value
	localparam int LEVEL_W    = 8;
	localparam int CLAMP_W    = 2;
	localparam int REG_IDX_W  = 3;
	localparam int NUM_CH     = 2;

	localparam int PP_W  = ERR_W + GAIN_W + 1;
	localparam int DP_W  = DIFF_W + GAIN_W + 1;
	localparam int IP_W  = INTEG_W + GAIN_W + 1;
	localparam int PROD_MAX_W = (IP_W > DP_W) ? IP_W : DP_W;
	localparam int ACC_W = PROD_MAX_W + 2;

	localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(255);

	// clamp_state codes
	localparam logic [CLAMP_W-1:0] CLAMP_NONE = 2'd0;
	localparam logic [CLAMP_W-1:0] CLAMP_HIGH = 2'd1;
	localparam logic [CLAMP_W-1:0] CLAMP_LOW  = 2'd2;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_PROP_L  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_INTEG_L = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_DERIV_L = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_PROP_R  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_INTEG_R = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_DERIV_R = 3'd5;

	localparam logic [GAIN_W-1:0] PROP_RESET  = GAIN_W'(1280);
	localparam logic [GAIN_W-1:0] INTEG_RESET = GAIN_W'(51);
	localparam logic [GAIN_W-1:0] DERIV_RESET = GAIN_W'(512);

	typedef struct packed {
		logic [GAIN_W-1:0] prop;
		logic [GAIN_W-1:0] integ;
		logic [GAIN_W-1:0] deriv;
	} gain_set_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic res;
	} stage_en_t;

	typedef struct packed {
		logic                      channel;
		logic signed [ERR_W-1:0]   err;
		logic signed [DIFF_W-1:0]  diff;
		logic signed [INTEG_W-1:0] integ;
	} err_item_t;

	typedef struct packed {
		logic signed [PP_W-1:0] prop_prod;
		logic signed [DP_W-1:0] deriv_prod;
		logic signed [IP_W-1:0] integ_prod;
	} prod_item_t;

endpackage

### rtl/core/spc_gain_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_gain_regs: gain register file
// Six Q8.8 gains, two sets, written through a plain write port.
// ----------------------------------------------------------------------------
module spc_gain_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          write_en,
	input  logic [spc_pkg::REG_IDX_W-1:0] write_index,
	input  logic [spc_pkg::GAIN_W-1:0]    write_data,
	output spc_pkg::gain_set_t [spc_pkg::NUM_CH-1:0] gains
);
	import spc_pkg::*;

	gain_set_t [NUM_CH-1:0] gains_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CH; c++) begin
				gains_q[c].prop  <= PROP_RESET;
				gains_q[c].integ <= INTEG_RESET;
				gains_q[c].deriv <= DERIV_RESET;
			end
		end else if (write_en) begin
			case (write_index)
				REG_PROP_L:  gains_q[0].prop  <= write_data;
				REG_INTEG_L: gains_q[0].integ <= write_data;
				REG_DERIV_L: gains_q[0].deriv <= write_data;
				REG_PROP_R:  gains_q[1].prop  <= write_data;
				REG_INTEG_R: gains_q[1].integ <= write_data;
				REG_DERIV_R: gains_q[1].deriv <= write_data;
				default: ;
			endcase
		end
	end

	assign gains = gains_q;

endmodule

### rtl/core/spc_err_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_err_stage: input register, error and integral update
// Holds per-channel integral and last error; updates them in item order.
// ----------------------------------------------------------------------------
module spc_err_stage (
	input  logic                         clk,
	input  logic                         arst_n,
	input  spc_pkg::stage_en_t           en,
	input  logic                         item_valid,
	input  logic                         channel,
	input  logic signed [spc_pkg::SPEED_W-1:0] target_speed,
	input  logic signed [spc_pkg::SPEED_W-1:0] measured_speed,
	output logic                         valid_s1,
	output logic                         valid_s2,
	output spc_pkg::err_item_t           item_s2
);
	import spc_pkg::*;

	logic                      channel_s1;
	logic signed [SPEED_W-1:0] target_s1;
	logic signed [SPEED_W-1:0] measured_s1;

	logic signed [INTEG_W-1:0] error_sum_q [NUM_CH];
	logic signed [ERR_W-1:0]   prev_err_q  [NUM_CH];

	logic signed [ERR_W-1:0]   err;
	logic signed [DIFF_W-1:0]  diff;
	logic signed [INTEG_W:0]   integ_sum;
	logic signed [INTEG_W-1:0] integ_next;
	logic                      update;

	localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
	localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

	always_comb begin
		err       = ERR_W'(target_s1) - ERR_W'(measured_s1);
		diff      = DIFF_W'(err) - DIFF_W'(prev_err_q[channel_s1]);
		integ_sum = (INTEG_W+1)'(error_sum_q[channel_s1]) + (INTEG_W+1)'(err);
		// saturate when the carry out disagrees with the sign
		if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1])
			integ_next = integ_sum[INTEG_W] ? INTEG_MIN : INTEG_MAX;
		else
			integ_next = integ_sum[INTEG_W-1:0];
	end

	assign update = en.s2 && valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			for (int c = 0; c < NUM_CH; c++) begin
				error_sum_q[c] <= '0;
				prev_err_q[c]  <= '0;
			end
		end else begin
			if (en.s1)
				valid_s1 <= item_valid;
			if (en.s2)
				valid_s2 <= valid_s1;
			if (update) begin
				error_sum_q[channel_s1] <= integ_next;
				prev_err_q[channel_s1]  <= err;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.s1 && item_valid) begin
			channel_s1  <= channel;
			target_s1   <= target_speed;
			measured_s1 <= measured_speed;
		end
		if (update) begin
			item_s2.channel <= channel_s1;
			item_s2.err     <= err;
			item_s2.diff    <= diff;
			item_s2.integ   <= integ_next;
		end
	end

endmodule

### rtl/core/spc_product_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_product_stage: gain multiplies
// Three exact signed products in Q.20, registered.
// ----------------------------------------------------------------------------
module spc_product_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	input  spc_pkg::stage_en_t   en,
	input  logic                 valid_s2,
	input  spc_pkg::err_item_t   item_s2,
	input  spc_pkg::gain_set_t [spc_pkg::NUM_CH-1:0] gains,
	output logic                 valid_s3,
	output spc_pkg::prod_item_t  prod_s3
);
	import spc_pkg::*;

	gain_set_t  g;
	prod_item_t prod;

	always_comb begin
		g = gains[item_s2.channel];
		prod.prop_prod  = $signed({1'b0, g.prop})  * item_s2.err;
		prod.deriv_prod = $signed({1'b0, g.deriv}) * item_s2.diff;
		prod.integ_prod = $signed({1'b0, g.integ}) * item_s2.integ;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s3 <= 1'b0;
		else if (en.s3)
			valid_s3 <= valid_s2;
	end

	always_ff @(posedge clk) begin
		if (en.s3 && valid_s2)
			prod_s3 <= prod;
	end

endmodule

### rtl/core/spc_level_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_level_stage: sum, floor and clamp
// Adds the products, floors to an integer and clamps to the PWM range.
// ----------------------------------------------------------------------------
module spc_level_stage (
	input  logic                          clk,
	input  logic                          arst_n,
	input  spc_pkg::stage_en_t            en,
	input  logic                          valid_s3,
	input  spc_pkg::prod_item_t           prod_s3,
	output logic                          result_valid,
	output logic [spc_pkg::LEVEL_W-1:0]   drive_level,
	output logic [spc_pkg::CLAMP_W-1:0]   clamp_state
);
	import spc_pkg::*;

	logic signed [ACC_W-1:0] acc;
	logic [LEVEL_W-1:0]      level;
	logic [CLAMP_W-1:0]      state;

	always_comb begin
		acc = ACC_W'(prod_s3.prop_prod) + ACC_W'(prod_s3.deriv_prod)
			+ ACC_W'(prod_s3.integ_prod);
		if (acc[ACC_W-1]) begin
			level = '0;
			state = CLAMP_LOW;
		end else if (|acc[ACC_W-2:FRAC_W+LEVEL_W]) begin
			level = LEVEL_MAX;
			state = CLAMP_HIGH;
		end else begin
			level = acc[FRAC_W+LEVEL_W-1:FRAC_W];
			state = CLAMP_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_valid <= 1'b0;
		else if (en.res)
			result_valid <= valid_s3;
	end

	always_ff @(posedge clk) begin
		if (en.res && valid_s3) begin
			drive_level <= level;
			clamp_state <= state;
		end
	end

endmodule

### rtl/core/dual_channel_pid_speed_control.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_channel_pid_speed_control: two-channel PID wheel-speed regulator
// Q4.12 speeds in, Q8.8 gains, clamped 0..255 PWM level out.
// ----------------------------------------------------------------------------
// Takes one item per clock unless item_stall is raised and returns one result
// per item, in order, through the input register, error and saturating integral
// update, three gain multiplies, then sum and clamp into the result register.
// The per-channel integral and last error are updated in the second stage, so
// items on the same channel may follow each other every cycle. A stall on the
// result side backs up only as far as the first empty stage. Gains are to be
// written through the write port while idle; the block does not enforce this.
module dual_channel_pid_speed_control (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  logic                                channel,
	input  logic signed [spc_pkg::SPEED_W-1:0]  target_speed,
	input  logic signed [spc_pkg::SPEED_W-1:0]  measured_speed,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic [spc_pkg::LEVEL_W-1:0]         drive_level,
	output logic [spc_pkg::CLAMP_W-1:0]         clamp_state,
	input  logic                                write_en,
	input  logic [spc_pkg::REG_IDX_W-1:0]       write_index,
	input  logic [spc_pkg::GAIN_W-1:0]          write_data
);
	import spc_pkg::*;

	gain_set_t [NUM_CH-1:0] gains;
	stage_en_t              en;
	logic                   valid_s1;
	logic                   valid_s2;
	logic                   valid_s3;
	err_item_t              item_s2;
	prod_item_t             prod_s3;

	// a stage loads when it is empty or its contents move on
	always_comb begin
		en.res = !result_valid || !result_stall;
		en.s3  = !valid_s3 || en.res;
		en.s2  = !valid_s2 || en.s3;
		en.s1  = !valid_s1 || en.s2;
	end

	assign item_stall = !en.s1;

	spc_gain_regs u_gain_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.write_en   (write_en),
		.write_index(write_index),
		.write_data (write_data),
		.gains      (gains)
	);

	spc_err_stage u_err_stage (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.item_valid    (item_valid),
		.channel       (channel),
		.target_speed  (target_speed),
		.measured_speed(measured_speed),
		.valid_s1      (valid_s1),
		.valid_s2      (valid_s2),
		.item_s2       (item_s2)
	);

	spc_product_stage u_product_stage (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.valid_s2(valid_s2),
		.item_s2 (item_s2),
		.gains   (gains),
		.valid_s3(valid_s3),
		.prod_s3 (prod_s3)
	);

	spc_level_stage u_level_stage (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.valid_s3    (valid_s3),
		.prod_s3     (prod_s3),
		.result_valid(result_valid),
		.drive_level (drive_level),
		.clamp_state (clamp_state)
	);

endmodule

### rtl/core/spc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_checker: port-level assertions for the speed regulator
// Clamp coding, latency, stall behavior; bound to the top level.
// ----------------------------------------------------------------------------
module spc_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               item_valid,
	input logic                               item_stall,
	input logic                               channel,
	input logic signed [spc_pkg::SPEED_W-1:0] target_speed,
	input logic signed [spc_pkg::SPEED_W-1:0] measured_speed,
	input logic                               result_valid,
	input logic                               result_stall,
	input logic [spc_pkg::LEVEL_W-1:0]        drive_level,
	input logic [spc_pkg::CLAMP_W-1:0]        clamp_state,
	input logic                               write_en,
	input logic [spc_pkg::REG_IDX_W-1:0]      write_index,
	input logic [spc_pkg::GAIN_W-1:0]         write_data
);
	import spc_pkg::*;

	// clamp code agrees with the level it reports
	a_clamp_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |->
			(clamp_state == CLAMP_NONE) ||
			(clamp_state == CLAMP_HIGH && drive_level == LEVEL_MAX) ||
			(clamp_state == CLAMP_LOW && drive_level == '0))
		else $error("clamp_state inconsistent with drive_level");

	// an empty output means the whole pipe can move
	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> !item_stall)
		else $error("input stalled with empty output");

	// an accepted item passes through the stage registers into the result register when the output flows
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall) ##1 !result_stall ##1 !result_stall
			##1 !result_stall |=> result_valid)
		else $error("result missing after pipeline latency");

	// stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=>
			(result_valid && $stable(drive_level) && $stable(clamp_state)))
		else $error("stalled result changed");

endmodule

bind dual_channel_pid_speed_control spc_checker u_spc_checker (.*);
